// ----- hdl/rarmt_pkg.sv -----
// rarmt_pkg: shared types, codes and helpers of the range-assign / range-extreme tree
// used by the controller, the datapath and the top level; depends on nothing

package rarmt_pkg;

	localparam int IN_W   = 11;
	localparam int DATA_W = 32;

	// node content after reset
	localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

	// configuration register indexes
	typedef enum logic {
		CFG_MAX_MODE    = 1'b0,
		CFG_EMPTY_VALUE = 1'b1
	} cfg_idx_t;

	// request opcodes
	typedef enum logic {
		OP_ASSIGN = 1'b0,
		OP_QUERY  = 1'b1
	} opcode_t;

	// one tree node as stored in memory
	typedef struct packed {
		logic                     pending;
		logic signed [DATA_W-1:0] tag;
		logic signed [DATA_W-1:0] node;
	} node_word_t;

	localparam int WORD_W = $bits(node_word_t);

	// memory read address select
	typedef enum logic [1:0] {
		RD_CUR = 2'd0,
		RD_C1  = 2'd1,
		RD_C2  = 2'd2,
		RD_COV = 2'd3
	} rd_sel_t;

	// memory write select
	typedef enum logic [2:0] {
		WR_NONE   = 3'd0,
		WR_CLEAR  = 3'd1,
		WR_C1     = 3'd2,
		WR_C2     = 3'd3,
		WR_PAR    = 3'd4,
		WR_ASSIGN = 3'd5,
		WR_FIX    = 3'd6
	} wr_sel_t;

	// level counter operation
	typedef enum logic [2:0] {
		SH_HOLD = 3'd0,
		SH_TOP  = 3'd1,
		SH_ONE  = 3'd2,
		SH_DEC  = 3'd3,
		SH_INC  = 3'd4
	} sh_op_t;

	// cover walk operation
	typedef enum logic [1:0] {
		COV_HOLD  = 2'd0,
		COV_INIT  = 2'd1,
		COV_ADV   = 2'd2,
		COV_SHIFT = 2'd3
	} cov_op_t;

	// controller states
	typedef enum logic [3:0] {
		S_CLEAR = 4'd0,
		S_IDLE  = 4'd1,
		S_CHECK = 4'd2,
		S_PSEL  = 4'd3,
		S_PWAIT = 4'd4,
		S_PC1   = 4'd5,
		S_PC2   = 4'd6,
		S_PP    = 4'd7,
		S_PNEXT = 4'd8,
		S_COV   = 4'd9,
		S_CMRG  = 4'd10,
		S_FIX   = 4'd11,
		S_FR2   = 4'd12,
		S_FW    = 4'd13,
		S_FNEXT = 4'd14,
		S_DONE  = 4'd15
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    cap_par;
		logic    cap_c1;
		logic    acc_init;
		logic    acc_merge;
		logic    out_load;
		logic    sel_set;
		logic    sel_clr;
		sh_op_t  sh_op;
		cov_op_t cov_op;
		rd_sel_t rd;
		wr_sel_t wr;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic empty_rng;
		logic query;
		logic node_act;
		logic pending;
		logic sel;
		logic sh_one;
		logic sh_top;
		logic cov_done;
		logic cov_act;
		logic out_busy;
	} status_t;

	// merge of two values by minimum or maximum
	function automatic logic signed [DATA_W-1:0] pick(
		input logic                     mx,
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		if (mx) begin
			return (a > b) ? a : b;
		end
		return (a < b) ? a : b;
	endfunction

endpackage

// ----- hdl/range_assign_range_min_tree.sv -----
// Range-assign / range-extreme lazy tree over LEAVES elements, one request at a time.
// After reset the node memory, 2*P words (P = LEAVES rounded up to a power of two), is
// swept with the request side stalled; config is taken.
// A request shares one memory port among a push walk of pending tags down both
// boundary paths, root first, a cover walk over the maximal covered nodes, and a fix-up
// of the partly covered nodes, deepest level first (assign only).
// An empty range skips the walks; results leave through an output register.

module range_assign_range_min_tree import rarmt_pkg::*; #(
	parameter int LEAVES = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic [IN_W-1:0]          left,
	input  logic [IN_W-1:0]          right,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] extreme
);

	cmd_t    cmd;
	status_t sts;

	// sequencer
	rarmt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// tree datapath and node memory
	rarmt_dp #(
		.LEAVES(LEAVES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.opcode   (opcode),
		.left     (left),
		.right    (right),
		.value    (value),
		.extreme  (extreme),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

// ----- hdl/rarmt_ram.sv -----
// rarmt_ram: generic single write port, single read port memory with registered read
// no dependencies

module rarmt_ram #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/rarmt_dp.sv -----
// rarmt_dp: datapath of the tree: configuration, request registers, node addressing,
// cover walk, accumulator, result register and the node memory; uses rarmt_pkg, rarmt_ram

module rarmt_dp import rarmt_pkg::*; #(
	parameter int LEAVES = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	input  logic                     opcode,
	input  logic [IN_W-1:0]          left,
	input  logic [IN_W-1:0]          right,
	input  logic signed [DATA_W-1:0] value,
	output logic signed [DATA_W-1:0] extreme,
	output logic                     out_valid,
	input  logic                     out_stall,
	input  cmd_t                     cmd,
	output status_t                  sts
);

	localparam int D  = $clog2(LEAVES);
	localparam int P  = 1 << D;
	localparam int AW = D + 1;
	localparam int EW = AW + 1;
	localparam int SW = $clog2(D + 1);
	localparam int XW = (AW > IN_W) ? AW : IN_W;
	localparam logic [AW-1:0] PNODE = AW'(P);

	logic                     max_mode_q;
	logic signed [DATA_W-1:0] empty_q;
	logic [AW-1:0]            l_q, r_q;
	logic                     op_q;
	logic signed [DATA_W-1:0] x_q;
	logic [SW-1:0]            sh_q;
	logic                     sel_q;
	logic [AW:0]              lo_q, hi_q;
	logic signed [DATA_W-1:0] acc_q;
	logic                     accv_q;
	node_word_t               par_q;
	logic signed [DATA_W-1:0] c1_q;
	logic [AW-1:0]            clr_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] extreme_q;

	logic [XW-1:0]            lim_x, left_x, right_x, lsat, rsat;
	logic [AW:0]              len, mask, l_e, r_e, l_len, hi_m1;
	logic                     fits, cov_a, cov_b;
	logic [AW-1:0]            node_a, node_b, cur, c1, c2, cov_tgt;
	logic                     we;
	logic [AW-1:0]            waddr, raddr;
	node_word_t               wdata, rd;
	logic [WORD_W-1:0]        rd_raw;
	logic signed [DATA_W-1:0] fix_m;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_mode_q <= 1'b0;
			empty_q    <= INT_MAX;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAX_MODE:    max_mode_q <= cfg_data[0];
				CFG_EMPTY_VALUE: empty_q    <= cfg_data;
			endcase
		end
	end

	// bound saturation
	assign lim_x   = XW'(LEAVES);
	assign left_x  = XW'(left);
	assign right_x = XW'(right);
	assign lsat    = (left_x > lim_x) ? lim_x : left_x;
	assign rsat    = (right_x > lim_x) ? lim_x : right_x;

	// request registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			l_q  <= lsat[AW-1:0];
			r_q  <= rsat[AW-1:0];
			op_q <= opcode;
			x_q  <= value;
		end
	end

	// node on the left and right boundary paths at the current level
	assign l_e    = {1'b0, l_q};
	assign r_e    = {1'b0, r_q};
	assign len    = EW'(1) << sh_q;
	assign mask   = len - EW'(1);
	assign l_len  = l_e + len;
	assign fits   = l_len <= r_e;
	assign cov_a  = ((l_e & mask) == '0) && fits;
	assign cov_b  = ((r_e & mask) == '0) && fits;
	assign node_a = (PNODE + l_q) >> sh_q;
	assign node_b = (PNODE + r_q - AW'(1)) >> sh_q;
	assign cur    = sel_q ? node_b : node_a;
	assign c1     = {cur[AW-2:0], 1'b0};
	assign c2     = {cur[AW-2:0], 1'b1};

	// level counter and boundary select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q  <= '0;
			sel_q <= 1'b0;
		end else begin
			unique case (cmd.sh_op)
				SH_HOLD: ;
				SH_TOP:  sh_q <= SW'(D);
				SH_ONE:  sh_q <= SW'(1);
				SH_DEC:  sh_q <= sh_q - SW'(1);
				SH_INC:  sh_q <= sh_q + SW'(1);
				default: ;
			endcase
			if (cmd.sel_set) begin
				sel_q <= 1'b1;
			end else if (cmd.sel_clr) begin
				sel_q <= 1'b0;
			end
		end
	end

	// bottom-up cover walk over the maximal covered nodes
	assign hi_m1   = hi_q - EW'(1);
	assign cov_tgt = lo_q[0] ? lo_q[AW-1:0] : hi_m1[AW-1:0];

	always_ff @(posedge clk) begin
		unique case (cmd.cov_op)
			COV_HOLD: ;
			COV_INIT: begin
				lo_q <= EW'(P) + l_e;
				hi_q <= EW'(P) + r_e;
			end
			COV_ADV: begin
				if (lo_q[0]) begin
					lo_q <= lo_q + EW'(1);
				end else begin
					hi_q <= hi_m1;
				end
			end
			COV_SHIFT: begin
				lo_q <= lo_q >> 1;
				hi_q <= hi_q >> 1;
			end
		endcase
	end

	// captured parent word and first child value
	always_ff @(posedge clk) begin
		if (cmd.cap_par) begin
			par_q <= rd;
		end
		if (cmd.cap_c1) begin
			c1_q <= rd.node;
		end
	end

	// query accumulator, seeded with the empty value when a walk skips a span
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accv_q <= 1'b0;
		end else if (cmd.acc_init) begin
			accv_q <= !((l_q == '0) && (r_e == EW'(P)));
		end else if (cmd.acc_merge) begin
			accv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_init) begin
			acc_q <= empty_q;
		end else if (cmd.acc_merge) begin
			acc_q <= accv_q ? pick(max_mode_q, acc_q, rd.node) : rd.node;
		end
	end

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.wr == WR_CLEAR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// memory ports
	assign fix_m = pick(max_mode_q, c1_q, rd.node);

	always_comb begin
		unique case (cmd.rd)
			RD_CUR: raddr = cur;
			RD_C1:  raddr = c1;
			RD_C2:  raddr = c2;
			RD_COV: raddr = cov_tgt;
		endcase
	end

	always_comb begin
		we    = 1'b1;
		waddr = cur;
		wdata = '{pending: 1'b0, tag: par_q.tag, node: par_q.node};
		unique case (cmd.wr)
			WR_NONE: we = 1'b0;
			WR_CLEAR: begin
				waddr = clr_q;
				wdata = '{pending: 1'b0, tag: INT_MAX, node: INT_MAX};
			end
			WR_C1: begin
				waddr = c1;
				wdata = '{pending: 1'b1, tag: par_q.tag, node: par_q.tag};
			end
			WR_C2: begin
				waddr = c2;
				wdata = '{pending: 1'b1, tag: par_q.tag, node: par_q.tag};
			end
			WR_PAR: ;
			WR_ASSIGN: begin
				waddr = cov_tgt;
				wdata = '{pending: 1'b1, tag: x_q, node: x_q};
			end
			WR_FIX: wdata = '{pending: 1'b0, tag: fix_m, node: fix_m};
			default: we = 1'b0;
		endcase
	end

	rarmt_ram #(
		.WIDTH(WORD_W),
		.DEPTH(2 * P)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_raw)
	);

	assign rd = node_word_t'(rd_raw);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			extreme_q <= acc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign extreme   = extreme_q;

	// status to the controller
	assign sts.clr_last  = &clr_q;
	assign sts.empty_rng = l_q >= r_q;
	assign sts.query     = (opcode_t'(op_q) == OP_QUERY);
	assign sts.node_act  = sel_q ? (!cov_b && (node_b != node_a)) : !cov_a;
	assign sts.pending   = rd.pending;
	assign sts.sel       = sel_q;
	assign sts.sh_one    = (sh_q == SW'(1));
	assign sts.sh_top    = (sh_q == SW'(D));
	assign sts.cov_done  = lo_q >= hi_q;
	assign sts.cov_act   = lo_q[0] | hi_q[0];
	assign sts.out_busy  = out_valid_q & out_stall;

endmodule

// ----- hdl/rarmt_ctrl.sv -----
// rarmt_ctrl: controller state machine sequencing clear sweep, push-down, cover and fix-up
// uses rarmt_pkg

module rarmt_ctrl import rarmt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.wr = WR_CLEAR;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.acc_init = 1'b1;
				cmd.sh_op    = SH_TOP;
				cmd.sel_clr  = 1'b1;
				if (sts.empty_rng) begin
					state_d = sts.query ? S_DONE : S_IDLE;
				end else begin
					state_d = S_PSEL;
				end
			end
			// push pending tags down the boundary paths, root first
			S_PSEL: begin
				if (sts.node_act) begin
					cmd.rd  = RD_CUR;
					state_d = S_PWAIT;
				end else begin
					state_d = S_PNEXT;
				end
			end
			S_PWAIT: begin
				cmd.cap_par = 1'b1;
				state_d     = sts.pending ? S_PC1 : S_PNEXT;
			end
			S_PC1: begin
				cmd.wr  = WR_C1;
				state_d = S_PC2;
			end
			S_PC2: begin
				cmd.wr  = WR_C2;
				state_d = S_PP;
			end
			S_PP: begin
				cmd.wr  = WR_PAR;
				state_d = S_PNEXT;
			end
			S_PNEXT: begin
				if (!sts.sel) begin
					cmd.sel_set = 1'b1;
					state_d     = S_PSEL;
				end else begin
					cmd.sel_clr = 1'b1;
					if (sts.sh_one) begin
						cmd.cov_op = COV_INIT;
						state_d    = S_COV;
					end else begin
						cmd.sh_op = SH_DEC;
						state_d   = S_PSEL;
					end
				end
			end
			// assign or read the maximal covered nodes
			S_COV: begin
				if (sts.cov_done) begin
					if (sts.query) begin
						state_d = S_DONE;
					end else begin
						cmd.sh_op   = SH_ONE;
						cmd.sel_clr = 1'b1;
						state_d     = S_FIX;
					end
				end else if (sts.cov_act) begin
					cmd.cov_op = COV_ADV;
					if (sts.query) begin
						cmd.rd  = RD_COV;
						state_d = S_CMRG;
					end else begin
						cmd.wr = WR_ASSIGN;
					end
				end else begin
					cmd.cov_op = COV_SHIFT;
				end
			end
			S_CMRG: begin
				cmd.acc_merge = 1'b1;
				state_d       = S_COV;
			end
			// recompute partly covered nodes, deepest level first
			S_FIX: begin
				if (sts.node_act) begin
					cmd.rd  = RD_C1;
					state_d = S_FR2;
				end else begin
					state_d = S_FNEXT;
				end
			end
			S_FR2: begin
				cmd.rd     = RD_C2;
				cmd.cap_c1 = 1'b1;
				state_d    = S_FW;
			end
			S_FW: begin
				cmd.wr  = WR_FIX;
				state_d = S_FNEXT;
			end
			S_FNEXT: begin
				if (!sts.sel) begin
					cmd.sel_set = 1'b1;
					state_d     = S_FIX;
				end else begin
					cmd.sel_clr = 1'b1;
					if (sts.sh_top) begin
						state_d = S_IDLE;
					end else begin
						cmd.sh_op = SH_INC;
						state_d   = S_FIX;
					end
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
		endcase
	end

endmodule

// ----- hdl/rarmt_chk.sv -----
// rarmt_chk: port-level checks of the tree's request and result channels
// bound to range_assign_range_min_tree; no package needed

module rarmt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] extreme
);

	// one request at a time: busy right after taking one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one still in progress");

	// a result only appears while a request is being worked on
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no request in progress");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(extreme))
		else $error("stalled result changed or dropped");

	// result leaves only when taken
	a_out_leave: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result dropped without being taken");

endmodule

bind range_assign_range_min_tree rarmt_chk u_chk (.*);

// ----- tb/tb_range_assign_range_min_tree.sv -----
// tb_range_assign_range_min_tree: self-checking bench for the range-assign / range-extreme tree
// drives requests from a directed table then random traffic, predicts with a lazy tree of its own
// depends on rarmt_pkg and range_assign_range_min_tree
`timescale 1ns / 100ps

module tb_range_assign_range_min_tree;
	import rarmt_pkg::*;

	localparam int LEAVES    = 1024;
	localparam int SPAN      = 1024;
	localparam int NODES     = 2 * SPAN;
	localparam int MAX_CYC   = 3000000;
	localparam int N_RANDOM  = 1000;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic                     cfg_index;
	logic [DATA_W-1:0]        cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic                     opcode;
	logic [IN_W-1:0]          left;
	logic [IN_W-1:0]          right;
	logic signed [DATA_W-1:0] value;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] extreme;

	range_assign_range_min_tree #(.LEAVES(LEAVES)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .left(left), .right(right), .value(value),
		.out_valid(out_valid), .out_stall(out_stall), .extreme(extreme)
	);

	// predicted tree state and registers
	logic signed [DATA_W-1:0] tree_val [NODES];
	logic                     tree_pend [NODES];
	logic signed [DATA_W-1:0] tree_tag [NODES];
	logic                     mdl_max;
	logic signed [DATA_W-1:0] mdl_empty;

	logic signed [DATA_W-1:0] expected_extremes[$];
	int  error_count;
	int  cycle_count = 0;
	bit  rx_calm;
	int  rx_hold;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYC) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic signed [DATA_W-1:0] merge2(logic signed [DATA_W-1:0] a,
			logic signed [DATA_W-1:0] b);
		if (mdl_max) begin
			return (a > b) ? a : b;
		end
		return (a < b) ? a : b;
	endfunction

	// move a pending assignment to both children
	function automatic void spread_tag(int k);
		int c1;
		int c2;
		c1 = 2 * k + 1;
		c2 = 2 * k + 2;
		if (!tree_pend[k] || c2 >= NODES) begin
			return;
		end
		tree_pend[k] = 1'b0;
		tree_val[c1] = tree_tag[k];
		tree_val[c2] = tree_tag[k];
		tree_pend[c1] = 1'b1;
		tree_pend[c2] = 1'b1;
		tree_tag[c1] = tree_tag[k];
		tree_tag[c2] = tree_tag[k];
	endfunction

	// recursive walk: assign when wr, otherwise gather the range extreme
	function automatic logic signed [DATA_W-1:0] tree_walk(int a, int b,
			logic signed [DATA_W-1:0] x, bit wr, int k, int lo, int hi);
		int mid;
		logic signed [DATA_W-1:0] vl;
		logic signed [DATA_W-1:0] vr;
		logic signed [DATA_W-1:0] m;
		if (k >= NODES) begin
			return mdl_empty;
		end
		if (hi <= a || b <= lo) begin
			return wr ? tree_val[k] : mdl_empty;
		end
		if (a <= lo && hi <= b) begin
			if (wr) begin
				tree_pend[k] = 1'b1;
				tree_tag[k] = x;
				tree_val[k] = x;
			end
			return tree_val[k];
		end
		spread_tag(k);
		mid = lo + (hi - lo) / 2;
		vl = tree_walk(a, b, x, wr, 2 * k + 1, lo, mid);
		vr = tree_walk(a, b, x, wr, 2 * k + 2, mid, hi);
		m = merge2(vl, vr);
		if (wr) begin
			tree_val[k] = m;
		end
		return m;
	endfunction

	// predict one request, queue a result for a query
	task automatic predict_request(logic op, logic [IN_W-1:0] l_in, logic [IN_W-1:0] r_in,
			logic signed [DATA_W-1:0] x);
		int l;
		int r;
		l = (l_in > LEAVES) ? LEAVES : l_in;
		r = (r_in > LEAVES) ? LEAVES : r_in;
		if (op == OP_ASSIGN) begin
			if (l < r) begin
				void'(tree_walk(l, r, x, 1'b1, 0, 0, SPAN));
			end
		end else begin
			expected_extremes.push_back((l < r) ? tree_walk(l, r, 0, 1'b0, 0, 0, SPAN)
				: mdl_empty);
		end
	endtask

	task automatic report_mismatch(string what, logic signed [DATA_W-1:0] got,
			logic signed [DATA_W-1:0] want);
		$display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	// result side: random stall bursts, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_hold <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_extremes.size() == 0) begin
					report_mismatch("unexpected extreme", extreme, 0);
				end else begin
					logic signed [DATA_W-1:0] want;
					want = expected_extremes.pop_front();
					if (extreme !== want) begin
						report_mismatch("extreme", extreme, want);
					end
				end
			end
			if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
				out_stall <= (rx_hold > 1);
			end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
				rx_hold <= $urandom_range(1, 5);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
			if (cycle_count == 40000) begin
				rx_hold <= 3000;
				out_stall <= 1'b1;
			end
		end
	end

	// directed rows
	typedef struct {
		logic                     op;
		logic [IN_W-1:0]          l;
		logic [IN_W-1:0]          r;
		logic signed [DATA_W-1:0] x;
		bit                       has_want;
		logic signed [DATA_W-1:0] want;
	} step_row_t;

	step_row_t directed_rows[$];

	task automatic send_request(logic op, logic [IN_W-1:0] l, logic [IN_W-1:0] r,
			logic signed [DATA_W-1:0] x, bit gaps);
		int g;
		if (gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			g = $urandom_range(1, 5);
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		left <= l;
		right <= r;
		value <= x;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_request(op, l, r, x);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_extremes.size() != 0) @(posedge clk);
		// an assign may still be walking the tree
		repeat (400) @(posedge clk);
	endtask

	task automatic write_cfg(cfg_idx_t idx, logic [DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MAX_MODE) begin
			mdl_max = d[0];
		end else begin
			mdl_empty = d;
		end
	endtask

	// random bound, biased to the edges and to out-of-range values
	function automatic logic [IN_W-1:0] rand_bound();
		case ($urandom_range(0, 9))
			0: return IN_W'($urandom_range(1025, 2047));
			1: return IN_W'(LEAVES);
			2: return '0;
			default: return IN_W'($urandom_range(0, 1024));
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom_range(0, 20) - 10;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		step_row_t row;
		logic [IN_W-1:0] l;
		logic [IN_W-1:0] r;
		int w;
		error_count = 0;
		rx_calm = 1'b0;
		mdl_max = 1'b0;
		mdl_empty = INT_MAX;
		for (int i = 0; i < NODES; i++) begin
			tree_val[i] = INT_MAX;
			tree_pend[i] = 1'b0;
			tree_tag[i] = INT_MAX;
		end
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MAX_MODE;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_ASSIGN;
		left = '0;
		right = '0;
		value = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: reset content, extremes, empty and saturated ranges
		directed_rows = '{
			'{OP_QUERY, 0, 1024, 0, 1, INT_MAX},
			'{OP_QUERY, 5, 5, 0, 1, INT_MAX},
			'{OP_QUERY, 9, 3, 0, 1, INT_MAX},
			'{OP_ASSIGN, 0, 1024, 32'sh80000000, 0, 0},
			'{OP_QUERY, 0, 2047, 0, 1, 32'sh80000000},
			'{OP_ASSIGN, 10, 20, 7, 0, 0},
			'{OP_QUERY, 10, 20, 0, 1, 7},
			'{OP_QUERY, 0, 1024, 0, 1, 32'sh80000000},
			'{OP_ASSIGN, 0, 1024, 32'sh7fffffff, 0, 0},
			'{OP_ASSIGN, 1023, 2047, -3, 0, 0},
			'{OP_QUERY, 1023, 1024, 0, 1, -3},
			'{OP_QUERY, 2047, 2047, 0, 1, INT_MAX},
			'{OP_QUERY, 1500, 2000, 0, 1, INT_MAX},
			'{OP_ASSIGN, 0, 1, 100, 0, 0},
			'{OP_QUERY, 0, 2, 0, 1, 100},
			'{OP_ASSIGN, 300, 200, 1, 0, 0},
			'{OP_QUERY, 0, 1024, 0, 0, 0}
		};
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_request(row.op, row.l, row.r, row.x, 1'b1);
			if (row.has_want && expected_extremes.size() != 0 &&
					expected_extremes[$] !== row.want) begin
				report_mismatch("directed prediction", expected_extremes[$], row.want);
			end
		end
		wait_drained();

		// random phases across register settings, extremes among them
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: begin
					write_cfg(CFG_MAX_MODE, 1);
					write_cfg(CFG_EMPTY_VALUE, 32'h80000000);
				end
				2: begin
					write_cfg(CFG_EMPTY_VALUE, $urandom);
				end
				3: begin
					write_cfg(CFG_MAX_MODE, 0);
					write_cfg(CFG_EMPTY_VALUE, 32'h7fffffff);
				end
				4: begin
					write_cfg(CFG_MAX_MODE, $urandom_range(0, 1));
					write_cfg(CFG_EMPTY_VALUE, $urandom);
					rx_calm = 1'b1;
				end
				default: ;
			endcase
			for (int n = 0; n < N_RANDOM / 5; n++) begin
				l = rand_bound();
				w = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1024) : $urandom_range(0, 40);
				r = ($urandom_range(0, 9) == 0) ? rand_bound() : IN_W'(l + w);
				send_request($urandom_range(0, 1) ? OP_QUERY : OP_ASSIGN, l, r, rand_value(),
					!rx_calm);
				// one pause until every result is back
				if (ph == 2 && n == 50) begin
					wait_drained();
				end
			end
			wait_drained();
		end

		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
